// File: rtl/core/fcdma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdma_pkg
// Shared types, request codes and defaults for the four-channel DMA block.
// ----------------------------------------------------------------------------
package fcdma_pkg;

	localparam int NumChannelsDef = 4;
	localparam int FifoBurstDef   = 4;
	localparam int CountBitsDef   = 16;

	localparam logic [2:0] REQ_SETUP  = 3'd0;
	localparam logic [2:0] REQ_HBLANK = 3'd1;
	localparam logic [2:0] REQ_VBLANK = 3'd2;
	localparam logic [2:0] REQ_STEP   = 3'd3;
	localparam logic [2:0] REQ_FIFO   = 3'd4;

	localparam logic [1:0] MODE_INC    = 2'd0;
	localparam logic [1:0] MODE_DEC    = 2'd1;
	localparam logic [1:0] MODE_FIXED  = 2'd2;
	localparam logic [1:0] MODE_RELOAD = 2'd3;

	localparam logic [1:0] TIM_IMMED   = 2'd0;
	localparam logic [1:0] TIM_VBLANK  = 2'd1;
	localparam logic [1:0] TIM_HBLANK  = 2'd2;
	localparam logic [1:0] TIM_SPECIAL = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  channel;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] unit_count;
		logic [1:0]  dest_mode;
		logic [1:0]  source_mode;
		logic        word_units;
		logic        repeat_on;
		logic [1:0]  start_timing;
		logic        irq_on;
		logic        enable_bit;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  xfer_channel;
		logic [31:0] read_address;
		logic [31:0] write_address;
		logic        word_transfer;
		logic        has_transfer;
		logic        irq_request;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  dest_mode;
		logic [1:0]  source_mode;
		logic        word_units;
		logic        repeat_on;
		logic [1:0]  start_timing;
		logic        irq_on;
	} ctl_t;

	// controller -> datapath
	typedef struct packed {
		logic setup;
		logic trig;
		logic [1:0] trig_timing;
		logic step;
		logic fifo_start;
		logic fifo_beat;
		logic fifo_last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ch_ok;
	} dp_sts_t;

	function automatic logic [31:0] move_addr(input logic [31:0] a, input logic [1:0] m,
		input logic [31:0] st);
		logic [31:0] r;
		case (m)
			MODE_INC, MODE_RELOAD: r = a + st;
			MODE_DEC:              r = a - st;
			default:               r = a;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/fcdma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdma_ctrl
// Sequencer: takes an item, issues datapath commands, counts fifo beats.
// ----------------------------------------------------------------------------
module fcdma_ctrl #(
	parameter int FIFO_BURST = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  fcdma_pkg::dp_sts_t sts,
	output fcdma_pkg::dp_cmd_t cmd,
	input  logic               out_free
);
	import fcdma_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FIFO = 1'b1;
	localparam int BW = (FIFO_BURST > 1) ? $clog2(FIFO_BURST) : 1;

	logic          state_q;
	logic [BW-1:0] beat_q;
	logic          take;
	logic          fifo_go;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign take     = in_valid && in_ready;
	assign fifo_go  = (state_q == ST_FIFO) && out_free;

	always_comb begin
		cmd = '0;
		if (take) begin
			case (req_type)
				REQ_SETUP:  cmd.setup = sts.ch_ok;
				REQ_HBLANK: begin
					cmd.trig = 1'b1;
					cmd.trig_timing = TIM_HBLANK;
				end
				REQ_VBLANK: begin
					cmd.trig = 1'b1;
					cmd.trig_timing = TIM_VBLANK;
				end
				REQ_STEP:   cmd.step = 1'b1;
				REQ_FIFO:   cmd.fifo_start = sts.ch_ok;
				default:    ;
			endcase
		end
		if (fifo_go) begin
			cmd.fifo_beat = 1'b1;
			cmd.fifo_last = (beat_q == BW'(FIFO_BURST - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			beat_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && req_type == REQ_FIFO && sts.ch_ok) begin
						state_q <= ST_FIFO;
						beat_q  <= '0;
					end
				end
				ST_FIFO: begin
					if (fifo_go) begin
						if (cmd.fifo_last) state_q <= ST_IDLE;
						else beat_q <= beat_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/fcdma_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcdma_dp
// Channel register file, trigger priority, pointer stepping, result register.
// ----------------------------------------------------------------------------
module fcdma_dp #(
	parameter int NUM_CHANNELS = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcdma_pkg::in_item_t  in_item,
	input  fcdma_pkg::dp_cmd_t   cmd,
	output fcdma_pkg::dp_sts_t   sts,
	output fcdma_pkg::out_item_t out_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_free
);
	import fcdma_pkg::*;

	localparam int CB = (COUNT_BITS > 16) ? 16 : COUNT_BITS;

	logic [31:0]   src_q   [NUM_CHANNELS];
	logic [31:0]   dst_q   [NUM_CHANNELS];
	logic [31:0]   dre_q   [NUM_CHANNELS];
	logic [CB-1:0] cnt_q   [NUM_CHANNELS];
	logic [CB-1:0] cre_q   [NUM_CHANNELS];
	ctl_t          ctl_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] en_q;
	logic          act_q;
	logic [1:0]    ach_q;
	logic [1:0]    fch_q;
	out_item_t     res_q;
	logic          vld_q;

	logic          hit;
	logic [1:0]    hit_ch;
	logic [1:0]    a;
	logic          a_ok;
	ctl_t          c;
	logic [31:0]   stp;
	logic [CB-1:0] cnt_dec;
	logic          fire_step;
	logic          cmpl;
	logic [1:0]    fidx;
	logic          issue;
	out_item_t     res_d;

	assign out_free  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_item  = res_q;
	assign sts.ch_ok = ({30'd0, in_item.channel} < NUM_CHANNELS);

	always_comb begin
		hit = 1'b0;
		hit_ch = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (en_q[i] && ctl_q[i].start_timing == cmd.trig_timing) begin
				hit = 1'b1;
				hit_ch = 2'(i);
			end
		end
	end

	assign a    = ach_q;
	assign a_ok = ({30'd0, a} < NUM_CHANNELS);
	assign c    = a_ok ? ctl_q[a] : '0;
	assign stp  = c.word_units ? 32'd4 : 32'd2;
	assign cnt_dec = a_ok ? cnt_q[a] - 1'b1 : '0;
	assign fire_step = cmd.step && act_q && a_ok && en_q[a];
	assign cmpl = fire_step && (cnt_q[a] == '0 || cnt_dec == '0);
	assign fidx = in_item.channel;
	assign issue = fire_step || cmd.fifo_beat;

	always_comb begin
		res_d = '0;
		if (cmd.fifo_beat) begin
			res_d.xfer_channel  = fch_q;
			res_d.read_address  = src_q[fch_q];
			res_d.write_address = dst_q[fch_q];
			res_d.word_transfer = 1'b1;
			res_d.has_transfer  = 1'b1;
			res_d.irq_request   = cmd.fifo_last && ctl_q[fch_q].irq_on;
			res_d.last          = cmd.fifo_last;
		end else begin
			res_d.xfer_channel  = a;
			res_d.word_transfer = c.word_units;
			res_d.has_transfer  = (cnt_q[a] != '0);
			res_d.read_address  = (cnt_q[a] != '0) ? src_q[a] : '0;
			res_d.write_address = (cnt_q[a] != '0) ? dst_q[a] : '0;
			res_d.irq_request   = cmpl && c.irq_on;
			res_d.last          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				src_q[i] <= '0;
				dst_q[i] <= '0;
				dre_q[i] <= '0;
				cnt_q[i] <= '0;
				cre_q[i] <= '0;
				ctl_q[i] <= '0;
			end
			en_q  <= '0;
			act_q <= 1'b0;
			ach_q <= '0;
			fch_q <= '0;
			res_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (out_ready) vld_q <= 1'b0;
			if (issue) begin
				vld_q <= 1'b1;
				res_q <= res_d;
			end
			if (cmd.setup) begin
				src_q[fidx] <= in_item.source_address;
				dst_q[fidx] <= in_item.dest_address;
				dre_q[fidx] <= in_item.dest_address;
				cnt_q[fidx] <= in_item.unit_count[CB-1:0];
				cre_q[fidx] <= in_item.unit_count[CB-1:0];
				ctl_q[fidx] <= '{in_item.dest_mode, in_item.source_mode,
					in_item.word_units, in_item.repeat_on, in_item.start_timing,
					in_item.irq_on};
				en_q[fidx]  <= in_item.enable_bit;
				if (in_item.enable_bit && in_item.start_timing == TIM_IMMED) begin
					act_q <= 1'b1;
					ach_q <= fidx;
				end
			end
			if (cmd.trig && hit) begin
				act_q <= 1'b1;
				ach_q <= hit_ch;
			end
			if (cmd.step && act_q && a_ok && !en_q[a]) act_q <= 1'b0;
			if (fire_step) begin
				if (cnt_q[a] != '0) begin
					src_q[a] <= move_addr(src_q[a], c.source_mode, stp);
					dst_q[a] <= move_addr(dst_q[a], c.dest_mode, stp);
					cnt_q[a] <= cnt_dec;
				end
				if (cmpl) begin
					if (c.repeat_on) begin
						cnt_q[a] <= cre_q[a];
						if (c.dest_mode == MODE_RELOAD) dst_q[a] <= dre_q[a];
						if (c.start_timing != TIM_IMMED) act_q <= 1'b0;
					end else begin
						en_q[a] <= 1'b0;
						act_q   <= 1'b0;
					end
				end
			end
			if (cmd.fifo_start) fch_q <= fidx;
			if (cmd.fifo_beat) src_q[fch_q] <= src_q[fch_q] + 32'd4;
		end
	end
endmodule

// File: rtl/core/four_channel_dma_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_dma_controller
// Output: a step result is registered, valid in the cycle after acceptance.
// Throughput: one item per cycle while out_free is high; a fifo fill holds
// input while its FIFO_BURST beats issue through the single result register.
// Reset: arst_n clears all channel state, the active flag and the result.
// ----------------------------------------------------------------------------
module four_channel_dma_controller #(
	parameter int NUM_CHANNELS = fcdma_pkg::NumChannelsDef,
	parameter int FIFO_BURST   = fcdma_pkg::FifoBurstDef,
	parameter int COUNT_BITS   = fcdma_pkg::CountBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fcdma_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fcdma_pkg::out_item_t out_data
);
	import fcdma_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    out_free;

	fcdma_ctrl #(.FIFO_BURST(FIFO_BURST)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req_type(in_data.req_type),
		.sts, .cmd, .out_free
	);

	fcdma_dp #(.NUM_CHANNELS(NUM_CHANNELS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .sts, .out_item(out_data),
		.out_valid, .out_ready, .out_free
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("result changed while stalled");
	a_fifo_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fifo_beat |-> !in_ready)
		else $error("input taken during fifo burst");
	a_last_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.irq_request) |-> out_data.last)
		else $error("irq on non-last result");
endmodule

// File: dv/four_channel_dma_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_dma_controller_test
// Drives setup, blank events, transfer steps and fifo fills into the DMA
// block, predicts every transfer and interrupt from its own channel model and
// checks each result in order, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_test;
	import fcdma_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	four_channel_dma_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// channel model
	logic [31:0] src_ptr [4];
	logic [31:0] dst_ptr [4];
	logic [15:0] units_left [4];
	logic [31:0] dst_reload [4];
	logic [15:0] units_reload [4];
	ctl_t ctl [4];
	logic ch_en [4];
	logic busy;
	logic [1:0] busy_ch;

	in_item_t pending_items [$];
	out_item_t expected_xfers [$];
	int errors = 0;
	int n_items = 0;
	int n_xfers = 0;
	int n_irqs = 0;
	int cycles = 0;
	bit gaps_on = 1;
	bit hold_off = 0;
	bit feed_done = 0;
	bit in_taken = 0;

	function automatic logic [31:0] next_addr(logic [31:0] a, logic [1:0] m, logic [31:0] st);
		if (m == MODE_INC || m == MODE_RELOAD) return a + st;
		if (m == MODE_DEC) return a - st;
		return a;
	endfunction

	function automatic out_item_t xfer(logic [1:0] c, logic [31:0] rd, logic [31:0] wr,
		logic w, logic h, logic irq, logic lst);
		out_item_t o;
		o.xfer_channel = c; o.read_address = rd; o.write_address = wr;
		o.word_transfer = w; o.has_transfer = h; o.irq_request = irq; o.last = lst;
		return o;
	endfunction

	task automatic finish_channel(logic [1:0] a);
		if (ctl[a].repeat_on) begin
			units_left[a] = units_reload[a];
			if (ctl[a].dest_mode == MODE_RELOAD) dst_ptr[a] = dst_reload[a];
			if (ctl[a].start_timing != TIM_IMMED) busy = 0;
		end else begin
			ch_en[a] = 0;
			busy = 0;
		end
	endtask

	task automatic trigger_blank(logic [1:0] tim);
		for (int i = 0; i < 4; i++)
			if (ch_en[i] && ctl[i].start_timing == tim) begin
				busy = 1; busy_ch = i[1:0];
				return;
			end
	endtask

	task automatic predict_dma(in_item_t it);
		logic [1:0] a;
		logic [31:0] st, rd, wr;
		logic irq;
		case (it.req_type)
			REQ_SETUP: begin
				a = it.channel;
				src_ptr[a] = it.source_address;
				dst_ptr[a] = it.dest_address;
				dst_reload[a] = it.dest_address;
				units_left[a] = it.unit_count;
				units_reload[a] = it.unit_count;
				ctl[a] = {it.dest_mode, it.source_mode, it.word_units, it.repeat_on,
					it.start_timing, it.irq_on};
				ch_en[a] = it.enable_bit;
				if (it.enable_bit && it.start_timing == TIM_IMMED) begin
					busy = 1; busy_ch = a;
				end
			end
			REQ_HBLANK: trigger_blank(TIM_HBLANK);
			REQ_VBLANK: trigger_blank(TIM_VBLANK);
			REQ_STEP: begin
				if (busy) begin
					a = busy_ch;
					if (!ch_en[a]) begin
						busy = 0;
					end else begin
						st = ctl[a].word_units ? 32'd4 : 32'd2;
						irq = 0;
						if (units_left[a] != 0) begin
							rd = src_ptr[a]; wr = dst_ptr[a];
							dst_ptr[a] = next_addr(wr, ctl[a].dest_mode, st);
							src_ptr[a] = next_addr(rd, ctl[a].source_mode, st);
							units_left[a] = units_left[a] - 16'd1;
							if (units_left[a] == 0) begin
								irq = ctl[a].irq_on;
								finish_channel(a);
							end
							expected_xfers.push_back(xfer(a, rd, wr, ctl[a].word_units, 1, irq, 1));
						end else begin
							irq = ctl[a].irq_on;
							finish_channel(a);
							expected_xfers.push_back(xfer(a, 0, 0, ctl[a].word_units, 0, irq, 1));
						end
					end
				end
			end
			REQ_FIFO: begin
				a = it.channel;
				for (int k = 0; k < 4; k++) begin
					expected_xfers.push_back(xfer(a, src_ptr[a], dst_ptr[a], 1, 1,
						(k == 3) ? ctl[a].irq_on : 1'b0, k == 3));
					src_ptr[a] = src_ptr[a] + 32'd4;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("error at cycle %0d: %s got %h want %h", cycles, what, got, want);
	endtask

	// input acceptance
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			predict_dma(in_data);
			n_items++;
		end
	end

	// driver
	int in_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 0;
				end else if (gaps_on && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(1, 12);
					in_valid <= 0;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stalls
	int out_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off) out_ready <= 0;
			else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 12);
				out_ready <= 0;
			end else out_ready <= 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_xfers.size() == 0) begin
				report_mismatch("unexpected result", out_data.read_address, 0);
			end else begin
				w = expected_xfers.pop_front();
				n_xfers++;
				if (w.irq_request) n_irqs++;
				if (out_data.xfer_channel != w.xfer_channel)
					report_mismatch("xfer_channel", out_data.xfer_channel, w.xfer_channel);
				if (out_data.read_address != w.read_address)
					report_mismatch("read_address", out_data.read_address, w.read_address);
				if (out_data.write_address != w.write_address)
					report_mismatch("write_address", out_data.write_address, w.write_address);
				if (out_data.word_transfer != w.word_transfer)
					report_mismatch("word_transfer", out_data.word_transfer, w.word_transfer);
				if (out_data.has_transfer != w.has_transfer)
					report_mismatch("has_transfer", out_data.has_transfer, w.has_transfer);
				if (out_data.irq_request != w.irq_request)
					report_mismatch("irq_request", out_data.irq_request, w.irq_request);
				if (out_data.last != w.last)
					report_mismatch("last", out_data.last, w.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("four_channel_dma_controller: mismatch");
			$finish;
		end
	end

	function automatic in_item_t rand_item(logic [2:0] req);
		in_item_t it;
		it.req_type = req;
		it.channel = 2'($urandom_range(0, 3));
		it.source_address = $urandom;
		it.dest_address = $urandom;
		it.unit_count = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 5));
		it.dest_mode = 2'($urandom_range(0, 3));
		it.source_mode = 2'($urandom_range(0, 3));
		it.word_units = 1'($urandom_range(0, 1));
		it.repeat_on = 1'($urandom_range(0, 1));
		it.start_timing = 2'($urandom_range(0, 3));
		it.irq_on = 1'($urandom_range(0, 1));
		it.enable_bit = ($urandom_range(0, 4) != 0);
		return it;
	endfunction

	task automatic add_setup(logic [1:0] c, logic [31:0] s, logic [31:0] d, logic [15:0] n,
		logic [1:0] dm, logic [1:0] sm, logic w, logic r, logic [1:0] t, logic irq, logic en);
		in_item_t it;
		it = {REQ_SETUP, c, s, d, n, dm, sm, w, r, t, irq, en};
		pending_items.push_back(it);
	endtask

	task automatic add_req(logic [2:0] req, logic [1:0] c);
		in_item_t it;
		it = '0;
		it.req_type = req;
		it.channel = c;
		pending_items.push_back(it);
	endtask

	task automatic wait_drain();
		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_xfers.size() > 0) @(posedge clk);
	endtask

	initial begin
		in_item_t it;
		logic [2:0] r;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		for (int i = 0; i < 4; i++) begin
			src_ptr[i] = '0;
			dst_ptr[i] = '0;
			units_left[i] = '0;
			dst_reload[i] = '0;
			units_reload[i] = '0;
			ctl[i] = '0;
			ch_en[i] = 1'b0;
		end
		busy = 1'b0;
		busy_ch = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		add_req(REQ_STEP, 0);
		add_setup(0, 32'hFFFF_FFFC, 32'h0000_0000, 16'd2, MODE_INC, MODE_DEC, 1, 0,
			TIM_IMMED, 1, 1);
		add_req(REQ_STEP, 0);
		add_req(REQ_STEP, 0);
		add_req(REQ_STEP, 0);
		add_setup(1, 32'h1000, 32'h2000, 16'd1, MODE_RELOAD, MODE_RELOAD, 0, 1,
			TIM_HBLANK, 1, 1);
		add_req(REQ_HBLANK, 0);
		add_req(REQ_STEP, 0);
		add_req(REQ_STEP, 0);
		add_req(REQ_HBLANK, 0);
		add_req(REQ_STEP, 0);
		add_setup(2, 32'h3000, 32'h4000, 16'd0, MODE_FIXED, MODE_FIXED, 0, 1,
			TIM_VBLANK, 0, 1);
		add_req(REQ_VBLANK, 0);
		add_req(REQ_STEP, 0);
		add_setup(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, MODE_DEC, MODE_INC, 1, 0,
			TIM_SPECIAL, 1, 1);
		add_req(REQ_FIFO, 3);
		add_req(REQ_FIFO, 0);
		add_setup(2, 32'h0, 32'h0, 16'd3, MODE_INC, MODE_INC, 0, 0, TIM_IMMED, 0, 0);
		add_req(REQ_STEP, 0);
		add_req(3'd5, 0);
		add_req(3'd7, 3);
		add_setup(0, 32'h10, 32'h20, 16'd0, MODE_INC, MODE_INC, 0, 0, TIM_IMMED, 1, 1);
		add_req(REQ_STEP, 0);
		wait_drain();

		// back-pressure: receiver stalls while steps keep coming
		hold_off = 1;
		add_setup(1, 32'h100, 32'h200, 16'd40, MODE_INC, MODE_INC, 1, 0, TIM_IMMED, 1, 1);
		for (int i = 0; i < 10; i++) add_req(REQ_STEP, 0);
		add_req(REQ_FIFO, 1);
		repeat (60) @(posedge clk);
		@(negedge clk);
		hold_off = 0;
		wait_drain();

		// random: mostly steps, mixed with setups, blank events, fifo fills and noise
		for (int i = 0; i < 280; i++) begin
			if (i == 220) begin
				wait_drain();
				gaps_on = 0;
			end
			case ($urandom_range(0, 9))
				0, 1: pending_items.push_back(rand_item(REQ_SETUP));
				2: pending_items.push_back(rand_item(REQ_HBLANK));
				3: pending_items.push_back(rand_item(REQ_VBLANK));
				4: pending_items.push_back(rand_item(REQ_FIFO));
				9: begin
					r = 3'($urandom_range(0, 7));
					pending_items.push_back(rand_item(r));
				end
				default: pending_items.push_back(rand_item(REQ_STEP));
			endcase
		end
		wait_drain();
		repeat (20) @(posedge clk);

		$display("ran %0d items, checked %0d results with %0d interrupts", n_items, n_xfers,
			n_irqs);
		if (errors == 0 && expected_xfers.size() == 0) begin
			$display("four_channel_dma_controller: match");
		end else begin
			$display("four_channel_dma_controller: mismatch");
		end
		$finish;
	end

endmodule
